// File: hw/rtl/mant_pkg.sv
package mant_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 32;
    localparam int ENTRY_W             = 15;
    localparam logic [6:0] SUSTAIN_RESET = 7'd64;

    localparam logic [1:0] OP_PLAY = 2'd0;
    localparam logic [1:0] OP_STOP = 2'd1;
    localparam logic [1:0] OP_SEEK = 2'd2;

    localparam logic [1:0] KIND_NOTE_ON    = 2'd0;
    localparam logic [1:0] KIND_CONTROLLER = 2'd1;

    localparam logic OUT_NOTE       = 1'b0;
    localparam logic OUT_CONTROLLER = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FLUSH,
        ST_SUSTAIN,
        ST_SEARCH,
        ST_SHIFT,
        ST_NOTE_OFF
    } state_t;

    typedef struct packed {
        logic       overflow;
        logic       kind;
        logic       last;
        logic [7:0] channel;
        logic [6:0] pitch;
        logic [6:0] velocity;
        logic [6:0] controller;
        logic [6:0] value;
    } result_t;

endpackage

// File: hw/rtl/midi_active_note_tracker_core.sv
// Active-note tracker between a MIDI event source and a synthesiser. One input transaction is
// taken at a time; the next is accepted once every result of the previous one has been loaded
// into the output register. A note-on or controller event is accepted in ST_IDLE and its
// result is loaded in ST_EXEC, which waits while the output register is full. A note-off walks
// the note table through the single read port of the table RAM, one entry a cycle, and from the
// matching entry on moves each later entry down one place before its result is loaded.
// A stop or seek flush gives one note-off a cycle for each held note while the output is free,
// and a stop then adds its sustain-off. A stall on the result side holds the transaction. The
// sustain controller register may be written whenever the block is idle.
module midi_active_note_tracker_core
    import mant_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // channel, pitch, velocity, controller_number, controller_value, zero pad
    input  logic [39:0] s_tdata,
    // operation, event_kind, muted
    input  logic [4:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // out_channel, out_pitch, out_velocity, out_controller, out_value, zero pad
    output logic [39:0] m_tdata,
    // out_kind, overflow
    output logic [1:0]  m_tuser,
    output logic        m_tlast,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    state_t state_reg, state_next;

    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic [6:0]    sustain_reg;

    logic [1:0] op_reg;
    logic [1:0] kind_reg;
    logic [7:0] channel_reg;
    logic [6:0] pitch_reg;
    logic [6:0] velocity_reg;
    logic       muted_reg;
    logic [6:0] ctl_reg;
    logic [6:0] val_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    logic    out_valid_reg;
    result_t out_reg;
    logic    out_free;
    logic    out_load;
    result_t out_next;

    logic          s_accept;
    logic          at_last;
    logic [CW-1:0] last_idx;
    logic [ENTRY_W-1:0] key;
    logic          note_on;
    logic          note_off;

    function automatic logic [AW-1:0] last_idx_of(input logic [CW-1:0] i);
        logic [CW-1:0] d;
        d = i - ONE_C;
        return d[AW-1:0];
    endfunction

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign last_idx  = count_reg - ONE_C;
    assign at_last   = (idx_reg == last_idx);
    assign key       = {channel_reg, pitch_reg};
    assign note_on   = (op_reg == OP_PLAY) && (kind_reg == KIND_NOTE_ON) &&
                       (velocity_reg != 7'd0);
    assign note_off  = (op_reg == OP_PLAY) && (kind_reg == KIND_NOTE_ON) &&
                       (velocity_reg == 7'd0);

    mant_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_next[AW-1:0]),
        .rdata (ram_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if ((op_reg == OP_STOP) || (op_reg == OP_SEEK)) begin
                    if (count_reg != '0) begin
                        state_next = ST_FLUSH;
                    end else if (op_reg == OP_STOP) begin
                        state_next = ST_SUSTAIN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else if (note_off) begin
                    state_next = (count_reg != '0) ? ST_SEARCH : ST_IDLE;
                end else if (note_on && !muted_reg) begin
                    if (out_free) begin
                        state_next = ST_IDLE;
                    end
                end else if ((op_reg == OP_PLAY) && (kind_reg == KIND_CONTROLLER)) begin
                    if (out_free) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (out_free && at_last) begin
                    state_next = (op_reg == OP_STOP) ? ST_SUSTAIN : ST_IDLE;
                end
            end
            ST_SUSTAIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEARCH: begin
                if (ram_rdata == key) begin
                    state_next = at_last ? ST_NOTE_OFF : ST_SHIFT;
                end else if (at_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SHIFT: begin
                if (at_last) begin
                    state_next = ST_NOTE_OFF;
                end
            end
            ST_NOTE_OFF: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        idx_next   = idx_reg;
        count_next = count_reg;
        ram_we     = 1'b0;
        ram_waddr  = count_reg[AW-1:0];
        ram_wdata  = key;
        out_load   = 1'b0;
        out_next   = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    idx_next = '0;
                end
            end
            ST_EXEC: begin
                if (note_on && !muted_reg && out_free) begin
                    out_load          = 1'b1;
                    out_next.kind     = OUT_NOTE;
                    out_next.channel  = channel_reg;
                    out_next.pitch    = pitch_reg;
                    out_next.velocity = velocity_reg;
                    out_next.last     = 1'b1;
                    if (count_reg < DEPTH_C) begin
                        ram_we     = 1'b1;
                        count_next = count_reg + ONE_C;
                    end else begin
                        out_next.overflow = 1'b1;
                    end
                end else if ((op_reg == OP_PLAY) && (kind_reg == KIND_CONTROLLER) &&
                             out_free) begin
                    out_load            = 1'b1;
                    out_next.kind       = OUT_CONTROLLER;
                    out_next.channel    = channel_reg;
                    out_next.controller = ctl_reg;
                    out_next.value      = val_reg;
                    out_next.last       = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    out_load         = 1'b1;
                    out_next.kind    = OUT_NOTE;
                    out_next.channel = ram_rdata[14:7];
                    out_next.pitch   = ram_rdata[6:0];
                    out_next.last    = at_last && (op_reg == OP_SEEK);
                    if (at_last) begin
                        count_next = '0;
                    end else begin
                        idx_next = idx_reg + ONE_C;
                    end
                end
            end
            ST_SUSTAIN: begin
                if (out_free) begin
                    out_load            = 1'b1;
                    out_next.kind       = OUT_CONTROLLER;
                    out_next.controller = sustain_reg;
                    out_next.last       = 1'b1;
                end
            end
            ST_SEARCH: begin
                if (!at_last) begin
                    idx_next = idx_reg + ONE_C;
                end
            end
            ST_SHIFT: begin
                // move entry idx down one place
                ram_we    = 1'b1;
                ram_waddr = last_idx_of(idx_reg);
                ram_wdata = ram_rdata;
                if (!at_last) begin
                    idx_next = idx_reg + ONE_C;
                end
            end
            ST_NOTE_OFF: begin
                if (out_free) begin
                    out_load         = 1'b1;
                    out_next.kind    = OUT_NOTE;
                    out_next.channel = channel_reg;
                    out_next.pitch   = pitch_reg;
                    out_next.last    = 1'b1;
                    count_next       = count_reg - ONE_C;
                end
            end
            default: begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            sustain_reg   <= SUSTAIN_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready) begin
                sustain_reg <= cfg_data;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg       <= s_tuser[1:0];
            kind_reg     <= s_tuser[3:2];
            muted_reg    <= s_tuser[4];
            channel_reg  <= s_tdata[7:0];
            pitch_reg    <= s_tdata[14:8];
            velocity_reg <= s_tdata[21:15];
            ctl_reg      <= s_tdata[28:22];
            val_reg      <= s_tdata[35:29];
        end
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.value, out_reg.controller, out_reg.velocity,
                       out_reg.pitch, out_reg.channel};
    assign m_tuser  = {out_reg.overflow, out_reg.kind};
    assign m_tlast  = out_reg.last;

    // table never holds more notes than it has room for
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("note count beyond table depth");

    // a flush never writes the table
    a_flush_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH) |-> !ram_we)
        else $error("table written during flush");

    // the sustain-off only follows an emptied table
    a_sustain_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUSTAIN) |-> (count_reg == '0))
        else $error("sustain-off with notes still held");

    // a note-off search only runs over a non-empty table
    a_search_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SEARCH) || (state_reg == ST_SHIFT)) |-> (idx_reg < count_reg))
        else $error("table walk past note count");

endmodule

// File: hw/rtl/mant_ram.sv
module mant_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
